// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  // item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // control characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // tab stops every eight columns
  localparam logic [7:0] TAB_STEP = 8'd8;
  localparam logic [7:0] TAB_MASK = 8'hF8;

  // attribute placed in the high byte of a written cell
  localparam logic [15:0] CELL_ATTR = 16'h0700;

  // register indexes, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // register reset values
  localparam logic [7:0] WIDTH_RST  = 8'd80;
  localparam logic [5:0] HEIGHT_RST = 6'd25;

  // field widths
  localparam int COL_W   = 7;   // committed cursor column
  localparam int ROW_W   = 5;   // committed cursor row
  localparam int UW_W    = 9;   // clamped line width, at most MAX_COLUMNS
  localparam int UH_W    = 6;   // clamped line count
  localparam int WCOL_W  = 8;   // working column, holds column plus a tab step
  localparam int WROW_W  = 6;   // working row, holds row plus folded rows
  localparam int PA_W    = 15;  // row times width plus column

  // clamped screen geometry
  typedef struct packed {
    logic [UW_W-1:0] width;
    logic [UH_W-1:0] height;
  } tcw_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;        // latch the input word
    logic decode;        // apply the character to the working cursor
    logic put_store;     // write the character cell
    logic wrap_step;     // fold one line of column into the row
    logic scroll_setup;  // size the scroll and park the cursor on the last row
    logic sc_read;       // read the scroll source cell
    logic sc_write;      // write the scroll destination cell
    logic clr_write;     // clear one cell after reset
    logic commit;        // working cursor to cursor registers
    logic capture_read;  // take the read cell
    logic load_out;      // fill the output register
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic is_nul;
    logic is_print;
    logic wrap_needed;
    logic scroll_needed;
    logic sc_last;
    logic clr_last;
    logic out_free;
  } tcw_sts_t;

endpackage

// ===== rtl/core/tcw_in_if.sv =====
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_code;
  logic [11:0] cell_index;

  modport source (output valid, output kind, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input kind, input char_code, input cell_index,
                output ready);
endinterface

// ===== rtl/core/tcw_out_if.sv =====
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_line;
  logic        end_mark;

  modport source (output valid, output cell_value, output cursor_column,
                  output cursor_line, output end_mark, input ready);
  modport sink (input valid, input cell_value, input cursor_column,
                input cursor_line, input end_mark, output ready);
endinterface

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tcw_cfg.sv =====
module tcw_cfg #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_LINES   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tcw_pkg::tcw_cfg_t cfg
);
  import tcw_pkg::*;

  logic [7:0] width_r;
  logic [5:0] height_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes, word index from paddr[2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[7:0];
        REG_HEIGHT: height_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {24'h0, width_r};
      REG_HEIGHT: prdata = {26'h0, height_r};
      default:    prdata = 32'h0;
    endcase
  end

  // clamp to the geometry the store supports
  always_comb begin
    if (width_r < 8'd8) begin
      cfg.width = UW_W'(8);
    end else if (int'(width_r) > MAX_COLUMNS) begin
      cfg.width = UW_W'(MAX_COLUMNS);
    end else begin
      cfg.width = UW_W'(width_r);
    end
    if (height_r == 6'd0) begin
      cfg.height = UH_W'(1);
    end else if (int'(height_r) > MAX_LINES) begin
      cfg.height = UH_W'(MAX_LINES);
    end else begin
      cfg.height = height_r;
    end
  end

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DECODE   = 9'b000000100,
    S_STORE    = 9'b000001000,
    S_WRAP     = 9'b000010000,
    S_SC_READ  = 9'b000100000,
    S_SC_WRITE = 9'b001000000,
    S_RDWAIT   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_read) begin
          state_nxt = S_RDWAIT;
        end else if (sts.is_nul) begin
          state_nxt = S_DONE;
        end else begin
          cmd.decode = 1'b1;
          state_nxt  = sts.is_print ? S_STORE : S_WRAP;
        end
      end
      S_STORE: begin
        cmd.put_store = 1'b1;
        state_nxt     = S_WRAP;
      end
      S_WRAP: begin
        if (sts.wrap_needed) begin
          cmd.wrap_step = 1'b1;
        end else if (sts.scroll_needed) begin
          cmd.scroll_setup = 1'b1;
          state_nxt        = S_SC_READ;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_SC_READ: begin
        cmd.sc_read = 1'b1;
        state_nxt   = S_SC_WRITE;
      end
      S_SC_WRITE: begin
        cmd.sc_write = 1'b1;
        if (sts.sc_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SC_READ;
        end
      end
      S_RDWAIT: begin
        cmd.capture_read = 1'b1;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/tcw_dp.sv =====
module tcw_dp #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_LINES   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::tcw_cmd_t cmd,
  output tcw_pkg::tcw_sts_t sts,
  input  tcw_pkg::tcw_cfg_t cfg,
  input  logic              in_kind,
  input  logic [7:0]        in_char_code,
  input  logic [11:0]       in_cell_index,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [15:0]       out_cell_value,
  output logic [6:0]        out_cursor_column,
  output logic [4:0]        out_cursor_line,
  output logic              out_end_mark
);
  import tcw_pkg::*;

  localparam int STORE_CELLS = MAX_COLUMNS * MAX_LINES;
  localparam int AW          = $clog2(STORE_CELLS);
  localparam int CW          = $clog2(STORE_CELLS + 1);
  localparam int SW          = CW + 1;

  // latched word
  logic              kind_r;
  logic [7:0]        char_r;
  logic [11:0]       idx_r;
  logic [15:0]       cell_r;

  // cursor and working cursor
  logic [COL_W-1:0]  col_reg_r;
  logic [ROW_W-1:0]  row_reg_r;
  logic [WCOL_W-1:0] col_w_r;
  logic [WROW_W-1:0] row_w_r;
  logic [PA_W-1:0]   addr_r;

  // sweep counter and scroll geometry
  logic [AW-1:0]     d_r;
  logic [CW-1:0]     shift_cells_r;
  logic [CW-1:0]     hw_r;

  // output register
  logic              out_valid_r;
  logic [15:0]       out_cell_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_end_r;

  logic [WCOL_W-1:0] col_ext;
  logic [WCOL_W-1:0] dec_col;
  logic [WROW_W-1:0] dec_row;
  logic [PA_W-1:0]   put_addr;
  logic              put_addr_ok;
  logic              idx_ok;
  logic [UH_W-1:0]   shift_raw;
  logic [UH_W-1:0]   shift;
  logic [SW-1:0]     src;
  logic              src_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;

  assign col_ext = WCOL_W'(col_reg_r);

  // cursor move for one character
  always_comb begin
    dec_col = col_ext;
    dec_row = WROW_W'(row_reg_r);
    case (char_r)
      CH_LF: begin
        dec_row = WROW_W'(row_reg_r) + WROW_W'(1);
        dec_col = '0;
      end
      CH_CR: begin
        dec_col = '0;
      end
      CH_TAB: begin
        dec_col = (col_ext + TAB_STEP) & TAB_MASK;
      end
      CH_BS: begin
        if (col_reg_r != '0) begin
          dec_col = col_ext - WCOL_W'(1);
        end
      end
      default: begin
        dec_col = col_ext + WCOL_W'(1);
      end
    endcase
  end

  assign put_addr    = PA_W'(row_reg_r) * PA_W'(cfg.width) + PA_W'(col_reg_r);
  assign put_addr_ok = int'(addr_r) < STORE_CELLS;
  assign idx_ok      = int'(idx_r) < STORE_CELLS;

  // lines to scroll, at most the whole screen
  assign shift_raw = UH_W'(row_w_r) - cfg.height + UH_W'(1);
  assign shift     = (shift_raw > cfg.height) ? cfg.height : shift_raw;

  // scroll source cell, past the screen it reads as blank
  assign src    = SW'(d_r) + SW'(shift_cells_r);
  assign src_ok = src < SW'(hw_r);

  // status
  assign sts.is_read       = (kind_r == KIND_READ);
  assign sts.is_nul        = (char_r == CH_NUL);
  assign sts.is_print      = (char_r != CH_LF) && (char_r != CH_CR) &&
                             (char_r != CH_TAB) && (char_r != CH_BS);
  assign sts.wrap_needed   = UW_W'(col_w_r) >= cfg.width;
  assign sts.scroll_needed = row_w_r >= WROW_W'(cfg.height);
  assign sts.sc_last       = CW'(d_r) == (hw_r - CW'(1));
  assign sts.clr_last      = d_r == AW'(STORE_CELLS - 1);
  assign sts.out_free      = !out_valid_r || out_ready;

  // store port selection
  assign ram_we    = cmd.clr_write | cmd.sc_write | (cmd.put_store & put_addr_ok);
  assign ram_waddr = cmd.put_store ? AW'(addr_r) : d_r;
  assign ram_raddr = cmd.sc_read ? AW'(src) : AW'(idx_r);

  always_comb begin
    if (cmd.put_store) begin
      ram_wdata = CELL_ATTR | {8'h00, char_r};
    end else if (cmd.sc_write && src_ok) begin
      ram_wdata = ram_rdata;
    end else begin
      ram_wdata = 16'h0000;
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (STORE_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // input word and read cell
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
      cell_r <= 16'h0000;
    end else if (cmd.capture_read) begin
      cell_r <= idx_ok ? ram_rdata : 16'h0000;
    end
  end

  // working cursor, store address, scroll geometry
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      col_w_r <= dec_col;
      row_w_r <= dec_row;
      addr_r  <= put_addr;
    end else if (cmd.wrap_step) begin
      col_w_r <= WCOL_W'(UW_W'(col_w_r) - cfg.width);
      row_w_r <= row_w_r + WROW_W'(1);
    end else if (cmd.scroll_setup) begin
      row_w_r       <= WROW_W'(cfg.height - UH_W'(1));
      shift_cells_r <= CW'(shift) * CW'(cfg.width);
      hw_r          <= CW'(cfg.height) * CW'(cfg.width);
    end
  end

  // cursor registers and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_reg_r <= '0;
      row_reg_r <= '0;
      d_r       <= '0;
    end else begin
      if (cmd.commit) begin
        col_reg_r <= col_w_r[COL_W-1:0];
        row_reg_r <= row_w_r[ROW_W-1:0];
      end
      if (cmd.scroll_setup) begin
        d_r <= '0;
      end else if (cmd.clr_write || cmd.sc_write) begin
        d_r <= d_r + AW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cell_r <= cell_r;
      out_col_r  <= col_reg_r;
      out_row_r  <= row_reg_r;
      out_end_r  <= (kind_r == KIND_PUT) && (char_r == CH_NUL);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = out_cell_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_line   = out_row_r;
  assign out_end_mark      = out_end_r;

endmodule

// ===== rtl/core/text_console_char_writer_top.sv =====
// channel   dir  handshake      word
// in_ch     in   valid/ready    kind, char_code, cell_index
// out_ch    out  valid/ready    cell_value, cursor_column, cursor_line, end_mark
// apb       in   psel/penable   screen_width at 0x0, screen_height at 0x4
//
// one word at a time: decode, then read wait for a read, store for a printed
// character, wrap for any character but NUL, and done for every word, with one
// more wrap step per line folded when the width wraps; a scroll does one store
// read then one store write per cell of the screen in use (height times width)
// through the single write port; after reset a clearing pass writes every cell
// once, MAX_COLUMNS*MAX_LINES cells (4096 by default), and no word is taken until
// it ends; a finished word waits in the output register, the next word is taken
// meanwhile and holds at its last step until that register frees
module text_console_char_writer_top #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_LINES   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  tcw_in_if.sink      in_ch,
  tcw_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  tcw_cfg_t cfg;
  tcw_cmd_t cmd;
  tcw_sts_t sts;
  logic     in_ready;

  tcw_cfg #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  tcw_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg),
    .in_kind           (in_ch.kind),
    .in_char_code      (in_ch.char_code),
    .in_cell_index     (in_ch.cell_index),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_cell_value    (out_ch.cell_value),
    .out_cursor_column (out_ch.cursor_column),
    .out_cursor_line   (out_ch.cursor_line),
    .out_end_mark      (out_ch.end_mark)
  );

endmodule
